// ----- hw/rtl/drt_pkg.sv -----
// ============================================================================
// drt_pkg: shared types and constants for the distance-vector route table
// Item and result codes, table entry layout, sequencer states.
// ============================================================================
`default_nettype none

package drt_pkg;

  localparam int ADDR_W  = 32;
  localparam int COST_W  = 5;
  localparam int HOP_W   = 4;
  localparam int TTL_W   = 16;
  localparam int CFG_W   = 16;

  // Configuration register indexes
  localparam logic CFG_COST_LIMIT = 1'b0;
  localparam logic CFG_MAX_TTL    = 1'b1;

  // Item kinds
  typedef enum logic [1:0] {
    FUNC_ADV    = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_DOWN   = 2'd3
  } func_t;

  // Result codes
  typedef enum logic [2:0] {
    STS_DONE     = 3'd0,
    STS_UPDATED  = 3'd1,
    STS_INSERTED = 3'd2,
    STS_KEPT     = 3'd3,
    STS_FULL     = 3'd4,
    STS_NOTFOUND = 3'd5,
    STS_FOUND    = 3'd6
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // One table entry as stored in the route RAM
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] cost;
    logic [HOP_W-1:0]  nexthop;
    logic [TTL_W-1:0]  ttl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- hw/rtl/drt_ram.sv -----
// ============================================================================
// drt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module drt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/distance_vector_route_table_top.sv -----
// ============================================================================
// distance_vector_route_table_top: distance-vector route table
// Routes keyed by 32-bit address; advertise, tick, lookup, interface down.
// ============================================================================
//
//  channel   ports                                         handshake
//  --------  --------------------------------------------  ---------------------
//  request   in_func, in_dest_address, in_adv_cost,        start & !busy
//            in_iface
//  result    out_status, out_route_nexthop, out_route_cost out_valid, 1 cycle
//  config    cfg_index, cfg_data                           cfg_valid & cfg_ready
//
//  Sweep: one shared sweep walks the filled part of the route RAM, one entry
//  per cycle through its single read port; the read data is registered. busy
//  stays high while the sweep runs, also on an empty table; a lookup or
//  advertisement that hits its route ends the sweep at that slot.
//  The result strobe goes high in the same cycle that busy falls. An
//  advertisement on an interface out of range never raises busy; its strobe
//  is in the cycle right after the accepting edge.
//  Reset: synchronous, active low; the table starts empty (fill count zero),
//  no clearing pass. The result strobe cannot be stalled by the receiver.
//
`default_nettype none

module distance_vector_route_table_top
  import drt_pkg::*;
#(
  parameter int TABLE_DEPTH    = 64,
  parameter int NUM_INTERFACES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_func,
  input  wire logic [ADDR_W-1:0] in_dest_address,
  input  wire logic [COST_W-1:0] in_adv_cost,
  input  wire logic [HOP_W-1:0]  in_iface,
  // result channel
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [HOP_W-1:0]       out_route_nexthop,
  output logic [COST_W-1:0]      out_route_cost,
  // configuration channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);       // RAM address bits
  localparam int CW = $clog2(TABLE_DEPTH + 1);   // counts 0..TABLE_DEPTH
  localparam logic [CW-1:0]      DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [HOP_W:0]     NUM_IF_C = (HOP_W+1)'(NUM_INTERFACES);
  localparam logic [COST_W-1:0]  COST_MAX = '1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t            state_r,      state_nxt;
  func_t             func_r,       func_nxt;
  logic [ADDR_W-1:0] addr_r,       addr_nxt;
  logic [HOP_W-1:0]  iface_r,      iface_nxt;
  logic [COST_W-1:0] nc_r,         nc_nxt;      // advertised cost + 1 hop
  logic [COST_W-1:0] inf_r,        inf_nxt;     // unreachable cost
  logic [CW-1:0]     scan_idx_r,   scan_idx_nxt;
  logic              pend_r,       pend_nxt;    // read data arrives this cycle
  logic [AW-1:0]     pend_idx_r,   pend_idx_nxt;
  logic [CW-1:0]     fill_r,       fill_nxt;    // routes occupy slots 0..fill-1
  logic [COST_W-1:0] cost_limit_r, cost_limit_nxt;
  logic [TTL_W-1:0]  max_ttl_r,    max_ttl_nxt;
  logic              out_valid_r,  out_valid_nxt;
  status_t           out_sts_r,    out_sts_nxt;
  logic [HOP_W-1:0]  out_hop_r,    out_hop_nxt;
  logic [COST_W-1:0] out_cost_r,   out_cost_nxt;

  // RAM side
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_ent;
  entry_t            ent;

  // Accept-time arithmetic
  logic [COST_W:0]   inf_sum;
  logic [COST_W-1:0] inf_now;
  logic [COST_W:0]   nc_sum;
  logic [COST_W-1:0] nc_now;
  logic              accept;

  // Sweep datapath
  logic              hit;
  logic [TTL_W-1:0]  ttl_dec;

  drt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent       = entry_t'(rd_data);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign out_valid         = out_valid_r;
  assign out_status        = out_sts_r;
  assign out_route_nexthop = out_hop_r;
  assign out_route_cost    = out_cost_r;

  // Unreachable = cost limit + 1, clamped to the cost field's top value
  assign inf_sum = {1'b0, cost_limit_r} + (COST_W+1)'(1);
  assign inf_now = inf_sum[COST_W] ? COST_MAX : inf_sum[COST_W-1:0];
  // One hop added, saturated at unreachable
  assign nc_sum  = {1'b0, in_adv_cost} + (COST_W+1)'(1);
  assign nc_now  = (nc_sum > {1'b0, inf_now}) ? inf_now : nc_sum[COST_W-1:0];

  // Aging: saturating decrement
  assign ttl_dec = (ent.ttl != '0) ? ent.ttl - TTL_W'(1) : '0;
  assign hit     = pend_r && (ent.addr == addr_r) &&
                   ((func_r == FUNC_ADV) || (func_r == FUNC_LOOKUP));

  // --------------------------------------------------------------------------
  // Next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    iface_nxt      = iface_r;
    nc_nxt         = nc_r;
    inf_nxt        = inf_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    fill_nxt       = fill_r;
    cost_limit_nxt = cost_limit_r;
    max_ttl_nxt    = max_ttl_r;
    out_valid_nxt  = 1'b0;
    out_sts_nxt    = out_sts_r;
    out_hop_nxt    = out_hop_r;
    out_cost_nxt   = out_cost_r;
    rd_en          = 1'b0;
    rd_addr        = scan_idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = pend_idx_r;
    wr_ent         = ent;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_COST_LIMIT: cost_limit_nxt = cfg_data[COST_W-1:0];
        CFG_MAX_TTL:    max_ttl_nxt    = cfg_data[TTL_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt     = func_t'(in_func);
          addr_nxt     = in_dest_address;
          iface_nxt    = in_iface;
          nc_nxt       = nc_now;
          inf_nxt      = inf_now;
          scan_idx_nxt = '0;
          if ((func_t'(in_func) == FUNC_ADV) && ({1'b0, in_iface} >= NUM_IF_C)) begin
            // bad interface: answer at once, table untouched
            out_valid_nxt = 1'b1;
            out_sts_nxt   = STS_DONE;
            out_hop_nxt   = '0;
            out_cost_nxt  = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // write-back of the entry read last cycle
        if (pend_r) begin
          case (func_r)
            FUNC_TICK: begin
              wr_en       = 1'b1;
              wr_ent.ttl  = ttl_dec;
              if (ttl_dec == '0) begin
                wr_ent.cost = inf_r;
              end
            end
            FUNC_DOWN: begin
              if (ent.nexthop == iface_r) begin
                wr_en       = 1'b1;
                wr_ent.cost = inf_r;
              end
            end
            default: ;
          endcase
        end

        if (hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (func_r == FUNC_LOOKUP) begin
            out_sts_nxt  = STS_FOUND;
            out_hop_nxt  = ent.nexthop;
            out_cost_nxt = ent.cost;
          end else if (ent.cost >= nc_r) begin
            wr_en          = 1'b1;
            wr_ent.cost    = nc_r;
            wr_ent.ttl     = max_ttl_r;
            wr_ent.nexthop = iface_r;
            out_sts_nxt    = STS_UPDATED;
            out_hop_nxt    = iface_r;
            out_cost_nxt   = nc_r;
          end else begin
            out_sts_nxt  = STS_KEPT;
            out_hop_nxt  = ent.nexthop;
            out_cost_nxt = ent.cost;
          end
        end else if (scan_idx_r < fill_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else if (!pend_r) begin
          // sweep finished without a hit
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_sts_nxt   = STS_DONE;
          out_hop_nxt   = '0;
          out_cost_nxt  = '0;
          case (func_r)
            FUNC_ADV: begin
              if (fill_r < DEPTH_C) begin
                wr_en          = 1'b1;
                wr_addr        = fill_r[AW-1:0];
                wr_ent.addr    = addr_r;
                wr_ent.cost    = nc_r;
                wr_ent.nexthop = iface_r;
                wr_ent.ttl     = max_ttl_r;
                fill_nxt       = fill_r + CW'(1);
                out_sts_nxt    = STS_INSERTED;
                out_hop_nxt    = iface_r;
                out_cost_nxt   = nc_r;
              end else begin
                out_sts_nxt = STS_FULL;
              end
            end
            FUNC_LOOKUP: out_sts_nxt = STS_NOTFOUND;
            default: ;
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      fill_r       <= '0;
      cost_limit_r <= COST_W'(15);
      max_ttl_r    <= TTL_W'(180);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      fill_r       <= fill_nxt;
      cost_limit_r <= cost_limit_nxt;
      max_ttl_r    <= max_ttl_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    addr_r     <= addr_nxt;
    iface_r    <= iface_nxt;
    nc_r       <= nc_nxt;
    inf_r      <= inf_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_sts_r  <= out_sts_nxt;
    out_hop_r  <= out_hop_nxt;
    out_cost_r <= out_cost_nxt;
  end

endmodule

`default_nettype wire

// ----- tb/tb_distance_vector_route_table_top.sv -----
// ============================================================================
// tb_distance_vector_route_table_top: route table self-checking testbench
// Directed corners first, then random advert/tick/lookup/down traffic over
// several cost limit / TTL settings. A local route table model predicts
// each reply; a monitor compares every result strobe with the oldest one.
// ============================================================================
`timescale 1ns / 100ps

module tb_distance_vector_route_table_top;
  import drt_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int NUM_INTERFACES = 16;
  localparam int POOL_SIZE      = 80;

  // Expected reply of one request
  typedef struct packed {
    status_t           status;
    logic [HOP_W-1:0]  hop;
    logic [COST_W-1:0] cost;
  } route_reply_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_func;
  logic [ADDR_W-1:0] in_dest_address;
  logic [COST_W-1:0] in_adv_cost;
  logic [HOP_W-1:0]  in_iface;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [HOP_W-1:0]  out_route_nexthop;
  logic [COST_W-1:0] out_route_cost;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Shadow route table and register copies
  bit                rt_valid [TABLE_DEPTH];
  logic [ADDR_W-1:0] rt_addr  [TABLE_DEPTH];
  logic [COST_W-1:0] rt_cost  [TABLE_DEPTH];
  logic [HOP_W-1:0]  rt_hop   [TABLE_DEPTH];
  logic [TTL_W-1:0]  rt_ttl   [TABLE_DEPTH];
  logic [COST_W-1:0] shadow_cost_limit;
  logic [TTL_W-1:0]  shadow_max_ttl;

  route_reply_t      route_reply_q[$];
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

  int mismatches;
  int req_count[4];
  int sts_count[8];
  int settings_used;

  distance_vector_route_table_top #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .NUM_INTERFACES(NUM_INTERFACES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_dest_address  (in_dest_address),
    .in_adv_cost      (in_adv_cost),
    .in_iface         (in_iface),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_route_nexthop(out_route_nexthop),
    .out_route_cost   (out_route_cost),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Route table prediction
  // --------------------------------------------------------------------------

  function automatic int find_route(logic [ADDR_W-1:0] addr);
    int hit;
    hit = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (rt_valid[i] && rt_addr[i] == addr) hit = i;
    end
    return hit;
  endfunction

  // Applies one request to the shadow table and returns the reply it earns.
  // An advert on an interface out of range changes nothing.
  function automatic route_reply_t predict_route_reply(func_t kind, logic [ADDR_W-1:0] addr,
                                                       logic [COST_W-1:0] adv,
                                                       logic [HOP_W-1:0] ifc);
    route_reply_t r;
    logic [COST_W-1:0] inf;
    logic [COST_W:0]   new_cost;
    int slot;
    int free_slot;
    r = '{STS_DONE, '0, '0};
    // unreachable = cost limit + 1, clamped to 5 bits
    inf = (shadow_cost_limit == 5'd31) ? 5'd31 : shadow_cost_limit + 5'd1;
    case (kind)
      FUNC_ADV: begin
        new_cost = {1'b0, adv} + 6'd1;
        if (new_cost > {1'b0, inf}) new_cost = {1'b0, inf};
        slot = find_route(addr);
        if (int'(ifc) >= NUM_INTERFACES) begin
          r = '{STS_DONE, '0, '0};
        end else if (slot >= 0) begin
          // ties replace the stored route and refresh it
          if ({1'b0, rt_cost[slot]} >= new_cost) begin
            rt_cost[slot] = new_cost[COST_W-1:0];
            rt_ttl[slot]  = shadow_max_ttl;
            rt_hop[slot]  = ifc;
            r = '{STS_UPDATED, ifc, new_cost[COST_W-1:0]};
          end else begin
            r = '{STS_KEPT, rt_hop[slot], rt_cost[slot]};
          end
        end else begin
          free_slot = -1;
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!rt_valid[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            r = '{STS_FULL, '0, '0};
          end else begin
            rt_valid[free_slot] = 1'b1;
            rt_addr[free_slot]  = addr;
            rt_cost[free_slot]  = new_cost[COST_W-1:0];
            rt_hop[free_slot]   = ifc;
            rt_ttl[free_slot]   = shadow_max_ttl;
            r = '{STS_INSERTED, ifc, new_cost[COST_W-1:0]};
          end
        end
      end
      FUNC_TICK: begin
        // single decrement per tick, expired routes go unreachable
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (rt_valid[i]) begin
            if (rt_ttl[i] != '0) rt_ttl[i] = rt_ttl[i] - TTL_W'(1);
            if (rt_ttl[i] == '0) rt_cost[i] = inf;
          end
        end
      end
      FUNC_LOOKUP: begin
        slot = find_route(addr);
        if (slot < 0) r = '{STS_NOTFOUND, '0, '0};
        else          r = '{STS_FOUND, rt_hop[slot], rt_cost[slot]};
      end
      default: begin
        // interface down: poison every route through it
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (rt_valid[i] && rt_hop[i] == ifc) rt_cost[i] = inf;
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request, config and pacing tasks (all entered right after a rising edge)
  // --------------------------------------------------------------------------

  // start stays high on return so back-to-back requests need no re-raise
  task automatic send_request(func_t kind, logic [ADDR_W-1:0] addr, logic [COST_W-1:0] adv,
                              logic [HOP_W-1:0] ifc);
    start           <= 1'b1;
    in_func         <= kind;
    in_dest_address <= addr;
    in_adv_cost     <= adv;
    in_iface        <= ifc;
    @(posedge clk);
    while (busy) @(posedge clk);
    route_reply_q.push_back(predict_route_reply(kind, addr, adv, ifc));
    req_count[kind]++;
  endtask

  task automatic request_gap();
    int n;
    n = $urandom_range(99);
    if (n < 60)      n = 0;
    else if (n < 90) n = $urandom_range(3, 1);
    else             n = $urandom_range(40, 10);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding reply has been checked
  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (route_reply_q.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_COST_LIMIT) shadow_cost_limit = value[COST_W-1:0];
    else                       shadow_max_ttl    = value[TTL_W-1:0];
  endtask

  task automatic set_config(logic [COST_W-1:0] cost_limit, logic [TTL_W-1:0] max_ttl);
    wait_for_replies();
    write_reg(CFG_COST_LIMIT, {{(CFG_W-COST_W){1'b0}}, cost_limit});
    write_reg(CFG_MAX_TTL, max_ttl);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Miss, tick and interface down on an empty table
  task automatic test_empty_table();
    send_request(FUNC_LOOKUP, 32'h0BAD_F00D, 5'd0, 4'd0);
    send_request(FUNC_TICK, 32'h0, 5'd0, 4'd0);
    send_request(FUNC_DOWN, 32'h0, 5'd0, 4'd7);
  endtask

  // Address, cost and iface extremes; cost 31 saturates at unreachable
  task automatic test_insert_and_lookup();
    send_request(FUNC_ADV, 32'h0000_0000, 5'd0, 4'd0);
    send_request(FUNC_ADV, 32'hFFFF_FFFF, 5'd31, 4'd15);
    send_request(FUNC_LOOKUP, 32'h0000_0000, 5'd31, 4'd15);
    send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 5'd0, 4'd0);
  endtask

  // Worse cost is kept, equal and better costs replace
  task automatic test_update_and_keep();
    send_request(FUNC_ADV, 32'h0000_0000, 5'd5, 4'd3);
    send_request(FUNC_ADV, 32'h0000_0000, 5'd0, 4'd9);
    send_request(FUNC_ADV, 32'hFFFF_FFFF, 5'd2, 4'd1);
  endtask

  task automatic test_interface_down();
    send_request(FUNC_DOWN, 32'h0, 5'd0, 4'd9);
    send_request(FUNC_LOOKUP, 32'h0000_0000, 5'd0, 4'd0);
  endtask

  // One-tick lifetime: the route expires on the first tick
  task automatic test_aging();
    set_config(5'd15, 16'd1);
    send_request(FUNC_ADV, 32'hA5A5_A5A5, 5'd3, 4'd5);
    send_request(FUNC_TICK, 32'h0, 5'd0, 4'd0);
    send_request(FUNC_LOOKUP, 32'hA5A5_A5A5, 5'd0, 4'd0);
  endtask

  // cost limit 0 (unreachable 1), zero lifetime, then cost limit 31 (clamped)
  task automatic test_unreachable_limits();
    set_config(5'd0, 16'd0);
    send_request(FUNC_ADV, 32'h5A5A_5A5A, 5'd0, 4'd2);
    send_request(FUNC_TICK, 32'h0, 5'd0, 4'd0);
    send_request(FUNC_LOOKUP, 32'h5A5A_5A5A, 5'd0, 4'd0);
    set_config(5'd31, 16'd0);
    send_request(FUNC_ADV, 32'h5A5A_5A5A, 5'd31, 4'd4);
    send_request(FUNC_ADV, 32'h1234_5678, 5'd30, 4'd6);
    send_request(FUNC_LOOKUP, 32'h1234_5678, 5'd0, 4'd0);
  endtask

  // Mostly adverts and lookups on a shared address pool so routes get hit,
  // refreshed, aged and poisoned; some lookups use fresh addresses (misses).
  task automatic test_random_traffic(int count, int pool_size, int drain_every);
    int    sel;
    bit    burst;
    func_t kind;
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] adv;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(3) == 0);
      sel  = $urandom_range(99);
      addr = addr_pool[$urandom_range(pool_size - 1)];
      adv  = ($urandom_range(3) == 0) ? COST_W'($urandom_range(31))
                                      : COST_W'($urandom_range(shadow_cost_limit));
      if (sel < 45)      kind = FUNC_ADV;
      else if (sel < 60) kind = FUNC_TICK;
      else if (sel < 90) kind = FUNC_LOOKUP;
      else               kind = FUNC_DOWN;
      if (kind == FUNC_LOOKUP && $urandom_range(4) == 0) addr = $urandom();
      send_request(kind, addr, adv, HOP_W'($urandom_range(15)));
      if (drain_every > 0 && i % drain_every == drain_every - 1) wait_for_replies();
      else if (!burst) request_gap();
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply monitor: one strobe, one reply, compared with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reply
    route_reply_t want;
    if (rst_n && out_valid) begin
      sts_count[out_status]++;
      if (route_reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected reply: status %0d hop %0d cost %0d", $realtime,
                   out_status, out_route_nexthop, out_route_cost);
      end else begin
        want = route_reply_q.pop_front();
        if (out_status !== want.status || out_route_nexthop !== want.hop ||
            out_route_cost !== want.cost) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] reply mismatch: expected status %0d hop %0d cost %0d, got %0d %0d %0d",
                     $realtime, want.status, want.hop, want.cost,
                     out_status, out_route_nexthop, out_route_cost);
        end
      end
    end
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #1_500_000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_func         <= FUNC_TICK;
    in_dest_address <= '0;
    in_adv_cost     <= '0;
    in_iface        <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_COST_LIMIT;
    cfg_data        <= '0;
    mismatches        = 0;
    settings_used     = 1;
    shadow_cost_limit = 5'd15;
    shadow_max_ttl    = 16'd180;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rt_valid[i] = 1'b0;
      rt_addr[i]  = '0;
      rt_cost[i]  = '0;
      rt_hop[i]   = '0;
      rt_ttl[i]   = '0;
    end
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, starting from reset register values
    test_empty_table();
    test_insert_and_lookup();
    test_update_and_keep();
    test_interface_down();
    test_aging();
    test_unreachable_limits();

    // random part; the last phase uses the full pool and overflows the table
    set_config(5'd1, 16'd2);
    test_random_traffic(250, 40, 0);
    set_config(5'd30, 16'd65535);
    test_random_traffic(250, 40, 0);
    set_config(5'd0, 16'd0);
    test_random_traffic(150, 40, 0);
    set_config(5'd31, 16'd1);
    test_random_traffic(200, 48, 0);
    set_config(5'd7, 16'd5);
    test_random_traffic(300, 48, 25);
    set_config(5'd15, 16'd3);
    test_random_traffic(580, POOL_SIZE, 0);

    wait_for_replies();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (route_reply_q.size() != 0) begin
      $display("%0d predicted replies never arrived", route_reply_q.size());
      mismatches += route_reply_q.size();
    end

    $display("Ran %0d adverts, %0d ticks, %0d lookups, %0d interface downs over %0d settings",
             req_count[FUNC_ADV], req_count[FUNC_TICK], req_count[FUNC_LOOKUP],
             req_count[FUNC_DOWN], settings_used);
    $display("Replies: %0d updated, %0d inserted, %0d kept, %0d full, %0d missed, %0d found",
             sts_count[STS_UPDATED], sts_count[STS_INSERTED], sts_count[STS_KEPT],
             sts_count[STS_FULL], sts_count[STS_NOTFOUND], sts_count[STS_FOUND]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
